@@ sv/pdu_pkg.sv @@
// ----------------------------------------------------------------------------
// pdu_pkg
// Shared types, codes and constants of the priority task dispatcher.
// ----------------------------------------------------------------------------
package pdu_pkg;

  localparam int MAX_TASKS_DEF = 32;

  localparam int PRIO_W  = 4;
  localparam int BURST_W = 16;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 22;
  localparam int OTIME_W = 21;
  localparam int WSUM_W  = 25;
  localparam int TSUM_W  = 26;
  localparam int TALLY_W = 6;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  typedef enum logic [1:0] {
    STAT_ADDED      = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP
  } state_t;

  typedef struct packed {
    logic               func;
    logic [PRIO_W-1:0]  task_priority;
    logic [BURST_W-1:0] task_burst;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] run_burst;
    logic [OTIME_W-1:0] wait_time;
    logic [OTIME_W-1:0] turnaround_time;
    logic [WSUM_W-1:0]  sum_wait;
    logic [TSUM_W-1:0]  sum_turnaround;
    logic [TALLY_W-1:0] dispatched_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic clr;
  } cell_ctl_t;

endpackage

@@ sv/pdu_cell.sv @@
// ----------------------------------------------------------------------------
// pdu_cell
// One task slot of the rotating task chain. It loads a new task, takes its
// neighbor's slot when the chain rotates, and drops its task on dispatch.
// ----------------------------------------------------------------------------
module pdu_cell
  import pdu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  slot_t     wr_data,
  input  slot_t     nbr,
  output slot_t     q
);

  logic               valid_r;
  logic               valid_nxt;
  logic [PRIO_W-1:0]  prio_r;
  logic [BURST_W-1:0] burst_r;
  logic [ID_W-1:0]    id_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.wr) begin
      valid_nxt = 1'b1;
    end else if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = nbr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      prio_r  <= wr_data.prio;
      burst_r <= wr_data.burst;
      id_r    <= wr_data.id;
    end else if (ctl.shift) begin
      prio_r  <= nbr.prio;
      burst_r <= nbr.burst;
      id_r    <= nbr.id;
    end
  end

  assign q = '{valid: valid_r, prio: prio_r, burst: burst_r, id: id_r};

endmodule

@@ sv/priority_task_dispatcher_unit.sv @@
// ----------------------------------------------------------------------------
// priority_task_dispatcher_unit
// Non-preemptive priority dispatcher built on a ring of task cells. The ring
// rotates past one comparator that keeps the best task of a full turn.
// ----------------------------------------------------------------------------
// Add, table full and empty schedule: the result is registered in the cycle
// after the input transaction; one input every cycle while out_stall is low.
// Schedule of N tasks: each dispatch is one full turn of the cell ring past
// the comparator in ST_SCAN, then ST_DISP issues it once the output is free.
// Reset clears all slot valid bits, the id counter, time and totals; no
// clearing pass is needed.
module priority_task_dispatcher_unit
  import pdu_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDXW = $clog2(MAX_TASKS);
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam logic [IDXW-1:0] LAST_POS = IDXW'(MAX_TASKS - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_TASKS);

  state_t state_r, state_nxt;

  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [ID_W-1:0]    id_ctr_r, id_ctr_nxt;
  logic [IDXW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic               best_found_r, best_found_nxt;
  logic [IDXW-1:0]    best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0]  best_prio_r, best_prio_nxt;
  logic [BURST_W-1:0] best_burst_r, best_burst_nxt;
  logic [ID_W-1:0]    best_id_r, best_id_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [WSUM_W-1:0]  wait_tot_r, wait_tot_nxt;
  logic [TSUM_W-1:0]  turn_tot_r, turn_tot_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic              in_acc;
  logic              out_free;
  logic              shift_en;
  logic              disp_go;
  logic              add_go;
  logic              take;
  logic [TIME_W-1:0] turn_w;
  slot_t             new_slot;
  slot_t             cell_q [MAX_TASKS];

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign add_go   = in_acc && (in_data.func == FUNC_ADD) && (cnt_r != FULL_CNT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_SCHED) && (cnt_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LAST_POS) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (out_free) begin
          state_nxt = (cnt_r == CNTW'(1)) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    shift_en = 1'b0;
    disp_go  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = !out_free;
      ST_SCAN: shift_en = 1'b1;
      ST_DISP: disp_go  = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // The slot at the head of the ring during scan cycle k is slot k, so a
  // later slot wins a tie; that is the newest task.
  assign take = cell_q[0].valid && (!best_found_r || (cell_q[0].prio >= best_prio_r));
  assign turn_w = elapsed_r + TIME_W'(best_burst_r);

  assign new_slot = '{valid: 1'b1, prio: in_data.task_priority,
                      burst: in_data.task_burst, id: id_ctr_r + ID_W'(1)};

  always_comb begin
    cnt_nxt        = cnt_r;
    id_ctr_nxt     = id_ctr_r;
    scan_cnt_nxt   = scan_cnt_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_burst_nxt = best_burst_r;
    best_id_nxt    = best_id_r;
    elapsed_nxt    = elapsed_r;
    wait_tot_nxt   = wait_tot_r;
    turn_tot_nxt   = turn_tot_r;
    tally_nxt      = tally_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.last = 1'b1;
      if (in_data.func == FUNC_ADD) begin
        if (cnt_r == FULL_CNT) begin
          out_data_nxt.status = STAT_FULL;
        end else begin
          id_ctr_nxt = new_slot.id;
          cnt_nxt    = cnt_r + CNTW'(1);
          out_data_nxt.status  = STAT_ADDED;
          out_data_nxt.task_id = new_slot.id;
        end
      end else begin
        elapsed_nxt  = '0;
        wait_tot_nxt = '0;
        turn_tot_nxt = '0;
        tally_nxt    = '0;
        scan_cnt_nxt   = '0;
        best_found_nxt = 1'b0;
        if (cnt_r == '0) begin
          out_data_nxt.status = STAT_EMPTY;
        end else begin
          out_valid_nxt = out_valid_r && out_stall;
          out_data_nxt  = out_data_r;
        end
      end
    end

    if (shift_en) begin
      scan_cnt_nxt = scan_cnt_r + IDXW'(1);
      if (take) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = scan_cnt_r;
        best_prio_nxt  = cell_q[0].prio;
        best_burst_nxt = cell_q[0].burst;
        best_id_nxt    = cell_q[0].id;
      end
    end

    if (disp_go) begin
      elapsed_nxt    = turn_w;
      wait_tot_nxt   = wait_tot_r + WSUM_W'(elapsed_r);
      turn_tot_nxt   = turn_tot_r + TSUM_W'(turn_w);
      tally_nxt      = tally_r + TALLY_W'(1);
      cnt_nxt        = cnt_r - CNTW'(1);
      scan_cnt_nxt   = '0;
      best_found_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_data_nxt.status           = STAT_DISPATCHED;
      out_data_nxt.task_id          = best_id_r;
      out_data_nxt.run_burst        = best_burst_r;
      out_data_nxt.wait_time        = elapsed_r[OTIME_W-1:0];
      out_data_nxt.turnaround_time  = turn_w[OTIME_W-1:0];
      out_data_nxt.sum_wait         = wait_tot_nxt;
      out_data_nxt.sum_turnaround   = turn_tot_nxt;
      out_data_nxt.dispatched_count = tally_nxt;
      out_data_nxt.last             = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      id_ctr_r     <= '0;
      scan_cnt_r   <= '0;
      best_found_r <= 1'b0;
      elapsed_r    <= '0;
      wait_tot_r   <= '0;
      turn_tot_r   <= '0;
      tally_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      id_ctr_r     <= id_ctr_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      best_found_r <= best_found_nxt;
      elapsed_r    <= elapsed_nxt;
      wait_tot_r   <= wait_tot_nxt;
      turn_tot_r   <= turn_tot_nxt;
      tally_r      <= tally_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_burst_r <= best_burst_nxt;
    best_id_r    <= best_id_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Ring of task cells; each takes its upper neighbor's slot on rotation.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = shift_en;
    assign ctl.wr    = add_go && (cnt_r[IDXW-1:0] == IDXW'(i));
    assign ctl.clr   = disp_go && (best_idx_r == IDXW'(i));

    pdu_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_data (new_slot),
      .nbr     (cell_q[(i + 1) % MAX_TASKS]),
      .q       (cell_q[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("task count exceeds table size");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a schedule is running");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (disp_go && (cnt_r == CNTW'(1))) |=> ((cnt_r == '0) && (state_r == ST_IDLE)
                                          && out_data_r.last))
    else $error("schedule did not end with an empty table");

  a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DISP) |-> best_found_r)
    else $error("dispatch without a selected task");

endmodule
